// ===== rtl/core/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit slice allocator: request
// and response beats, status and action codes, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

	// field widths of the request and response beats
	localparam int BYTES_W  = 16;
	localparam int FS_W     = 10;
	localparam int FC_W     = 11;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;
	localparam int COUNT_W  = 11;

	// slices needed: quotient plus header slice plus remainder slice
	localparam int NEED_W = BYTES_W + 1;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	// action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	typedef struct packed {
		logic               action;
		logic [BYTES_W-1:0] alloc_bytes;
		logic [FS_W-1:0]    free_start;
		logic [FC_W-1:0]    free_count;
	} slice_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  first_slice;
		logic [COUNT_W-1:0]  run_length;
	} slice_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic div_step;
		logic calc_need;
		logic eval;
		logic scan;
		logic mark_init;
		logic mark;
		logic fail;
		logic finish;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_free;
		logic bad;
		logic found;
		logic scan_end;
		logic mark_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_first_fit_slice_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_fit_slice_allocator
// First-fit allocator over a bitmap of slices, one bit per slice, msb first.
// ----------------------------------------------------------------------------
// Usage: drive req and raise start; the beat is taken at a clock edge with
// start high and busy low. busy stays high until the response is out. The
// response beat sits on rsp for exactly one cycle with done high and cannot
// be held off. One request is worked on at a time.
// An allocation goes through the divider, the size check, the bitmap scan
// and the marking pass; an allocation too large for the map fails at the
// size check, and one with no free run fails at the end of the scan. A free
// skips the divider and the scan, and a bad free fails at its check.
// The next request can be taken in the cycle after done. The scan reads one
// bitmap byte per cycle from the single memory read port, and marking does
// one byte read-modify-write per cycle.
// Reset clears the byte valid bits: the whole map reads as free at once,
// with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_slice_allocator
	import bffa_pkg::*;
#(
	parameter int N_SLICES    = 1024,
	parameter int SLICE_BYTES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire slice_req_t req,
	output logic            done,
	output slice_rsp_t      rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	bffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (req.action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// bitmap, divider and search
	bffa_dp #(
		.N_SLICES    (N_SLICES),
		.SLICE_BYTES (SLICE_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/core/bffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bffa_ctrl
// Controller of the slice allocator: sequences the size division, the request
// check, the bitmap scan and the read-modify-write marking pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ctrl
	import bffa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     action,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_NEED  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_MINIT = 3'd5;
	localparam logic [2:0] S_MARK  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = (action == ACT_FREE) ? S_EVAL : S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_nx     = S_NEED;
			end
			S_NEED: begin
				cmd.calc_need = 1'b1;
				state_nx      = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.bad) begin
					cmd.fail = 1'b1;
					state_nx = S_DONE;
				end else begin
					state_nx = stat.is_free ? S_MINIT : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_nx = S_MINIT;
				end else if (stat.scan_end) begin
					cmd.fail = 1'b1;
					state_nx = S_DONE;
				end
			end
			S_MINIT: begin
				cmd.mark_init = 1'b1;
				state_nx      = S_MARK;
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				if (stat.mark_last) begin
					cmd.finish = 1'b1;
					state_nx   = S_DONE;
				end
			end
			S_DONE: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/core/bffa_dp.sv =====
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath of the slice allocator: reciprocal-multiply size divider, bitmap
// memory with per-byte valid bits, byte-wide first-fit scan and run marking.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_dp
	import bffa_pkg::*;
#(
	parameter int N_SLICES    = 1024,
	parameter int SLICE_BYTES = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire slice_req_t req,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	output slice_rsp_t      rsp
);

	localparam int MAP_BYTES = (N_SLICES + 7) / 8;
	localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int SW        = AW + 3;
	localparam int CNTW      = $clog2(N_SLICES + 1);
	localparam int SBW       = $clog2(SLICE_BYTES + 1);
	localparam int PW        = BYTES_W + SBW;
	localparam int TAIL      = N_SLICES % 8;
	localparam int END_BYTE  = MAP_BYTES - 1;

	// reciprocal of the slice size, exact for every 16-bit byte count
	localparam int     RSH     = BYTES_W + $clog2(SLICE_BYTES);
	localparam int     RW      = BYTES_W + 1;
	localparam int     MW      = 2 * BYTES_W + 1;
	localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(SLICE_BYTES) - longint'(1))
		/ longint'(SLICE_BYTES);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

	// request registers
	logic              act_q;
	logic [FS_W-1:0]   fs_q;
	logic [FC_W-1:0]   fc_q;

	// divider
	logic [BYTES_W-1:0] bytes_q;
	logic [BYTES_W-1:0] quo_q;
	logic [NEED_W-1:0]  need_q;
	logic [MW-1:0]      div_prod;
	logic               rem_nz;

	// run registers
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   lo_q;
	logic [SW-1:0]   last_q;
	logic [CNTW-1:0] run_len_q;
	logic [SW-1:0]   run_start_q;

	// bitmap memory and read stage
	logic [7:0]           mem [MAP_BYTES];
	logic [MAP_BYTES-1:0] ent_vld_q;
	logic [AW-1:0]        rd_addr_q;
	logic                 vld_s1;
	logic [AW-1:0]        byte_s1;
	logic [7:0]           rdata_s1;
	logic                 rvalid_s1;
	logic [7:0]           map_byte;

	// scan and mark logic
	logic [CNTW-1:0] scan_len;
	logic [SW-1:0]   scan_start;
	logic [SW-1:0]   scan_where;
	logic            scan_fnd;
	logic [7:0]      mark_mask;
	logic [7:0]      mark_data;
	logic            mark_we;
	logic            bad_alloc;
	logic            bad_free;

	slice_rsp_t rsp_q;

	// quotient by reciprocal multiply, remainder seen by multiplying back
	assign div_prod = MW'(bytes_q) * MW'(RECIP);
	assign rem_nz   = ((PW'(quo_q) * PW'(SLICE_BYTES)) != PW'(bytes_q));

	// request checks
	assign bad_alloc = (32'(need_q) > 32'(N_SLICES));
	assign bad_free  = (fc_q == '0) || ((32'(fs_q) + 32'(fc_q)) > 32'(N_SLICES));

	// bytes not yet written read as free
	assign map_byte = rvalid_s1 ? rdata_s1 : 8'h00;

	// first-fit over one bitmap byte, msb first, run carried across bytes
	always_comb begin
		logic used;
		used       = 1'b0;
		scan_len   = run_len_q;
		scan_start = run_start_q;
		scan_where = run_start_q;
		scan_fnd   = 1'b0;
		for (int j = 0; j < 8; j++) begin
			used = map_byte[7-j] ||
				((TAIL != 0) && (byte_s1 == AW'(END_BYTE)) && (j >= TAIL));
			if (!scan_fnd) begin
				if (used) begin
					scan_len = '0;
				end else begin
					if (scan_len == '0)
						scan_start = {byte_s1, 3'(j)};
					scan_len = scan_len + CNTW'(1);
					if (scan_len >= cnt_q) begin
						scan_fnd   = 1'b1;
						scan_where = scan_start;
					end
				end
			end
		end
	end

	// bits of the current byte that lie inside the run
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			mark_mask[7-j] = ((byte_s1 != lo_q[SW-1:3]) || (3'(j) >= lo_q[2:0])) &&
				((byte_s1 != last_q[SW-1:3]) || (3'(j) <= last_q[2:0]));
		end
	end

	assign mark_data = (act_q == ACT_ALLOC) ? (map_byte | mark_mask)
		: (map_byte & (FULL_BYTE ^ mark_mask));
	assign mark_we   = cmd.mark && vld_s1;

	// status to controller
	always_comb begin
		stat           = '0;
		stat.is_free   = (act_q == ACT_FREE);
		stat.bad       = (act_q == ACT_FREE) ? bad_free : bad_alloc;
		stat.found     = vld_s1 && scan_fnd;
		stat.scan_end  = vld_s1 && !scan_fnd && (byte_s1 == AW'(END_BYTE));
		stat.mark_last = vld_s1 && (byte_s1 == last_q[SW-1:3]);
	end

	// control registers: entry valid bits, read address, read stage flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_addr_q <= '0;
			vld_s1    <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			vld_s1    <= cmd.scan || cmd.mark;
			rvalid_s1 <= ent_vld_q[rd_addr_q];
			if (mark_we)
				ent_vld_q[byte_s1] <= 1'b1;
			priority if (cmd.eval) begin
				rd_addr_q <= '0;
			end else if (cmd.mark_init) begin
				rd_addr_q <= lo_q[SW-1:3];
			end else if (cmd.scan || cmd.mark) begin
				rd_addr_q <= (rd_addr_q == AW'(END_BYTE)) ? rd_addr_q
					: rd_addr_q + AW'(1);
			end
		end
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr_q];
		byte_s1  <= rd_addr_q;
		if (mark_we)
			mem[byte_s1] <= mark_data;
	end

	// request capture and divider
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= req.action;
			fs_q    <= req.free_start;
			fc_q    <= req.free_count;
			bytes_q <= req.alloc_bytes;
		end
		if (cmd.div_step)
			quo_q <= BYTES_W'(div_prod >> RSH);
		if (cmd.calc_need)
			need_q <= NEED_W'(quo_q) + NEED_W'(1) + NEED_W'(rem_nz);
	end

	// run bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			cnt_q       <= (act_q == ACT_FREE) ? CNTW'(fc_q) : CNTW'(need_q);
			lo_q        <= SW'(fs_q);
			run_len_q   <= '0;
			run_start_q <= '0;
		end else if (cmd.scan && vld_s1) begin
			run_len_q   <= scan_len;
			run_start_q <= scan_start;
			if (scan_fnd)
				lo_q <= scan_where;
		end
		if (cmd.mark_init)
			last_q <= lo_q + SW'(cnt_q) - SW'(1);
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.fail) begin
			rsp_q.status      <= (act_q == ACT_FREE) ? ST_BAD_FREE : ST_NO_SPACE;
			rsp_q.first_slice <= '0;
			rsp_q.run_length  <= '0;
		end else if (cmd.finish) begin
			rsp_q.status      <= ST_OK;
			rsp_q.first_slice <= START_W'(lo_q);
			rsp_q.run_length  <= COUNT_W'(cnt_q);
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/bffa_checker.sv =====
// ----------------------------------------------------------------------------
// bffa_props
// Port-level checks of the slice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_props
	import bffa_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire slice_rsp_t rsp
);

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// the block is idle right after a response
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after response");

	// status carries a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_NO_SPACE ||
			rsp.status == ST_BAD_FREE))
		else $error("undefined status code");

	// a failed request reports an empty run
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.first_slice == '0 && rsp.run_length == '0))
		else $error("failed request reports a run");

endmodule

bind bitmap_first_fit_slice_allocator bffa_props u_bffa_props (.*);

`default_nettype wire

// ===== verif/bffa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bffa_checker
// Watches the request and response beats of the slice allocator, keeps its
// own copy of the slice bitmap, predicts each response and compares it.
// ----------------------------------------------------------------------------
module bffa_checker
	import bffa_pkg::*;
#(
	parameter int N_SLICES    = 1024,
	parameter int SLICE_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  slice_req_t req,
	input  logic       done,
	input  slice_rsp_t rsp,
	output int         errors,
	output int         outstanding
);

	// shadow bitmap, one entry per slice, 1 = used
	bit         used_map [N_SLICES];
	slice_rsp_t rsp_due_q [$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	// first-fit search and marking, or run clearing, on the shadow map
	function automatic slice_rsp_t predict_rsp(input slice_req_t beat);
		slice_rsp_t result;
		int         need;
		int         run_len;
		int         run_at;
		int         first;
		int         span;
		int         s;
		bit         hit;
		result = '0;
		result.status = ST_OK;
		run_len = 0;
		run_at = 0;
		hit = 1'b0;
		if (beat.action == ACT_ALLOC) begin
			// header slice plus one for a partial slice
			need = int'(beat.alloc_bytes) / SLICE_BYTES + 1;
			if (int'(beat.alloc_bytes) % SLICE_BYTES != 0)
				need++;
			if (need <= N_SLICES) begin
				for (s = 0; s < N_SLICES && !hit; s++) begin
					if (used_map[s]) begin
						run_len = 0;
					end else begin
						if (run_len == 0)
							run_at = s;
						run_len++;
						if (run_len >= need)
							hit = 1'b1;
					end
				end
			end
			if (hit) begin
				for (s = run_at; s < run_at + need; s++)
					used_map[s] = 1'b1;
				result.first_slice = START_W'(run_at);
				result.run_length = COUNT_W'(need);
			end else begin
				result.status = ST_NO_SPACE;
			end
		end else begin
			first = int'(beat.free_start);
			span = int'(beat.free_count);
			if (span == 0 || first + span > N_SLICES) begin
				result.status = ST_BAD_FREE;
			end else begin
				for (s = first; s < first + span; s++)
					used_map[s] = 1'b0;
				result.first_slice = beat.free_start;
				result.run_length = beat.free_count;
			end
		end
		return result;
	endfunction

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
		end
	endtask

	// mid-cycle sampling: inputs and outputs only move at the rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			// response beat against the oldest prediction
			if (done === 1'b1) begin
				if (rsp_due_q.size() == 0) begin
					errors++;
					$display("%0t: response beat with none expected, got %p", $time, rsp);
				end else begin
					check_field("status", rsp_due_q[0].status, rsp.status);
					check_field("first_slice", rsp_due_q[0].first_slice, rsp.first_slice);
					check_field("run_length", rsp_due_q[0].run_length, rsp.run_length);
					void'(rsp_due_q.pop_front());
				end
			end
			// request beat taken at the coming edge
			if (start === 1'b1 && busy === 1'b0)
				rsp_due_q.push_back(predict_rsp(req));
			outstanding <= rsp_due_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free beats into the slice allocator: a directed pass
// over sizes, holes, full map and bad frees, then random allocate and free
// beats with a redrawn allocate bias and random idle bursts. Checking is done by bffa_checker.
// ----------------------------------------------------------------------------
module testbench;
	import bffa_pkg::*;

	localparam int N_SLICES    = 1024;
	localparam int SLICE_BYTES = 4;
	localparam int N_RANDOM    = 1325;
	localparam int QUIET_TAIL  = 150;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		int at;
		int cnt;
	} slice_run_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       done;
	slice_req_t req;
	slice_rsp_t rsp;
	int         check_errors;
	int         check_pending;
	int         cycles = 0;

	logic       action_log [$];
	slice_run_t live_runs [$];

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bitmap_first_fit_slice_allocator #(
		.N_SLICES   (N_SLICES),
		.SLICE_BYTES(SLICE_BYTES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	bffa_checker #(
		.N_SLICES   (N_SLICES),
		.SLICE_BYTES(SLICE_BYTES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.errors     (check_errors),
		.outstanding(check_pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bitmap_first_fit_slice_allocator] ERROR");
			$finish;
		end
	end

	// remember granted runs so later frees can hit them
	always @(negedge clk) begin
		if (arst_n && done === 1'b1 && action_log.size() != 0) begin
			if (action_log.pop_front() == ACT_ALLOC && rsp.status == ST_OK)
				live_runs.push_back('{int'(rsp.first_slice), int'(rsp.run_length)});
		end
	end

	// unused fields carry random bits
	function automatic slice_req_t alloc_beat(input int nbytes);
		slice_req_t beat;
		beat = slice_req_t'({$urandom, $urandom});
		beat.action = ACT_ALLOC;
		beat.alloc_bytes = BYTES_W'(nbytes);
		return beat;
	endfunction

	function automatic slice_req_t free_beat(input int first, input int span);
		slice_req_t beat;
		beat = slice_req_t'({$urandom, $urandom});
		beat.action = ACT_FREE;
		beat.free_start = FS_W'(first);
		beat.free_count = FC_W'(span);
		return beat;
	endfunction

	// present a beat, wait for it to be taken, maybe idle afterwards
	task automatic send_beat(input slice_req_t beat, input bit allow_gap);
		req <= beat;
		start <= 1'b1;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		action_log.push_back(beat.action);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			req <= slice_req_t'({$urandom, $urandom});
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain_all();
		start <= 1'b0;
		while (check_pending != 0)
			@(posedge clk);
	endtask

	function automatic slice_req_t pick_alloc();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return alloc_beat($urandom_range(0, 63));
		else if (k < 85)
			return alloc_beat($urandom_range(64, 1023));
		else if (k < 95)
			return alloc_beat($urandom_range(1024, 4095));
		return alloc_beat($urandom_range(0, 65535));
	endfunction

	function automatic slice_req_t pick_free();
		slice_run_t run;
		int         idx;
		int         offs;
		if (live_runs.size() != 0 && $urandom_range(0, 99) < 85) begin
			idx = $urandom_range(0, live_runs.size() - 1);
			run = live_runs[idx];
			live_runs.delete(idx);
			// sometimes only part of the run
			if ($urandom_range(0, 4) == 0) begin
				offs = $urandom_range(0, run.cnt - 1);
				return free_beat(run.at + offs, $urandom_range(1, run.cnt - offs));
			end
			return free_beat(run.at, run.cnt);
		end
		case ($urandom_range(0, 3))
			0: return free_beat($urandom_range(0, 1023), 0);
			1: return free_beat($urandom_range(0, 1023), $urandom_range(0, 2047));
			2: return free_beat($urandom_range(900, 1023), $urandom_range(1, 200));
			default: return free_beat($urandom_range(0, 1023), $urandom_range(1, 64));
		endcase
	endfunction

	initial begin
		slice_req_t beat;
		int         fill_pct;
		bit         gap_on;
		bit         quiet;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		fill_pct = 70;
		gap_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sizes, holes, byte crossing, full map, bad frees
		send_beat(alloc_beat(0), 1'b1);
		send_beat(alloc_beat(1), 1'b1);
		send_beat(alloc_beat(4), 1'b1);
		send_beat(alloc_beat(5), 1'b1);
		send_beat(alloc_beat(65535), 1'b1);
		send_beat(free_beat(1, 2), 1'b1);
		send_beat(alloc_beat(0), 1'b1);
		send_beat(alloc_beat(4), 1'b1);
		send_beat(free_beat(5, 0), 1'b1);
		send_beat(free_beat(1000, 100), 1'b1);
		send_beat(free_beat(1023, 1), 1'b1);
		send_beat(free_beat(0, 1024), 1'b1);
		send_beat(free_beat(0, 2047), 1'b1);
		send_beat(free_beat(1, 1024), 1'b1);
		send_beat(alloc_beat(4092), 1'b1);
		send_beat(alloc_beat(0), 1'b1);
		send_beat(free_beat(1023, 1), 1'b1);
		send_beat(alloc_beat(0), 1'b1);
		send_beat(free_beat(8, 9), 1'b1);
		send_beat(alloc_beat(32), 1'b1);
		send_beat(alloc_beat(4096), 1'b1);
		send_beat(free_beat(0, 1024), 1'b1);
		send_beat(alloc_beat(12), 1'b1);
		send_beat(free_beat(1023, 1), 1'b1);

		// random: allocate bias redrawn every 200 beats, idle stretches on and off
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= N_RANDOM - QUIET_TAIL);
			if (i == N_RANDOM / 2)
				drain_all();
			if (i % 200 == 0)
				fill_pct = $urandom_range(40, 90);
			if (i % 100 == 0)
				gap_on = ($urandom_range(0, 2) != 0);
			if (live_runs.size() == 0 || $urandom_range(0, 99) < fill_pct)
				beat = pick_alloc();
			else
				beat = pick_free();
			send_beat(beat, gap_on && !quiet);
		end

		drain_all();
		repeat (300) @(posedge clk);
		if (check_errors == 0 && check_pending == 0)
			$display("[bitmap_first_fit_slice_allocator] OK");
		else
			$display("[bitmap_first_fit_slice_allocator] ERROR");
		$finish;
	end

endmodule
